// ----- hw/rtl/itp_pkg.sv -----
// Shared types, codes and lookup functions of the infix-to-postfix converter.
// No dependencies; every other file of the block but itp_ram imports this package.
package itp_pkg;

  // Operator stack codes
  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_OPEN = 3'd1;
  localparam logic [2:0] CODE_ADD  = 3'd2;
  localparam logic [2:0] CODE_SUB  = 3'd3;
  localparam logic [2:0] CODE_MUL  = 3'd4;
  localparam logic [2:0] CODE_DIV  = 3'd5;

  localparam int unsigned CODE_W = 3;

  // Status codes of a result
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW    = 2'd1;
  localparam logic [1:0] STATUS_UNMATCHED_C = 2'd2;
  localparam logic [1:0] STATUS_UNMATCHED_O = 2'd3;

  // ASCII characters handled
  localparam logic [7:0] CHAR_OPEN  = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE = 8'h29;  // )
  localparam logic [7:0] CHAR_MUL   = 8'h2A;  // *
  localparam logic [7:0] CHAR_ADD   = 8'h2B;  // +
  localparam logic [7:0] CHAR_SUB   = 8'h2D;  // -
  localparam logic [7:0] CHAR_DIV   = 8'h2F;  // /

  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LETTER,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic [1:0] status;
    logic       expression_done;
    logic       run_last;
  } out_item_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] code;
    logic [7:0] symbol;
    logic       end_of_expression;
  } cmd_t;

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] p;
    p = 2'd0;
    case (code)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] c;
    c = 8'h00;
    case (code)
      CODE_OPEN: c = CHAR_OPEN;
      CODE_ADD:  c = CHAR_ADD;
      CODE_SUB:  c = CHAR_SUB;
      CODE_MUL:  c = CHAR_MUL;
      CODE_DIV:  c = CHAR_DIV;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// Top level of the infix-to-postfix converter: front end, command queue, back end.
// Depends on itp_pkg, itp_front, itp_back and itp_ram.
//
// Converts an infix expression, one ASCII character per input transfer, to
// postfix with an operator stack of STACK_DEPTH entries held in a RAM with
// registered read. The front end classifies each character and queues it in a
// two-entry command queue, so input transfers continue while the back end works.
// The back end takes each command in its idle state and handles it in its main
// state; after each push or pop it waits for the RAM read of the new stack top,
// and an end of expression flushes every stacked entry in the same way.
// Ignored characters without the end flag are dropped at the input and cost
// nothing. Results leave through an output register; the last result of each
// input is marked, held until the next result or idle shows that it is last.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  itp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hw/rtl/itp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/itp_front.sv -----
// Front end: accepts input characters, classifies them and queues commands.
// Depends on itp_pkg.
module itp_front import itp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  localparam int unsigned PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t          fifo_q [CMD_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  cmd_t          cmd_new;
  logic          accept, wr_en, rd_en;

  always_comb begin
    cmd_new                   = '0;
    cmd_new.symbol            = in_item_i.symbol;
    cmd_new.end_of_expression = in_item_i.end_of_expression;
    cmd_new.kind              = KIND_NONE;
    cmd_new.code              = CODE_NONE;
    unique case (in_item_i.symbol) inside
      [8'h41:8'h5A], [8'h61:8'h7A]: cmd_new.kind = KIND_LETTER;
      CHAR_OPEN: begin
        cmd_new.kind = KIND_OPEN;
        cmd_new.code = CODE_OPEN;
      end
      CHAR_CLOSE: cmd_new.kind = KIND_CLOSE;
      CHAR_ADD: begin
        cmd_new.kind = KIND_OPER;
        cmd_new.code = CODE_ADD;
      end
      CHAR_SUB: begin
        cmd_new.kind = KIND_OPER;
        cmd_new.code = CODE_SUB;
      end
      CHAR_MUL: begin
        cmd_new.kind = KIND_OPER;
        cmd_new.code = CODE_MUL;
      end
      CHAR_DIV: begin
        cmd_new.kind = KIND_OPER;
        cmd_new.code = CODE_DIV;
      end
      default: cmd_new.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != CW'(CMD_QUEUE_DEPTH));
  assign accept      = in_valid_i && in_ready_o;
  // drop ignored characters that do not close the expression
  assign wr_en       = accept && ((cmd_new.kind != KIND_NONE) || cmd_new.end_of_expression);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- hw/rtl/itp_back.sv -----
// Back end: runs queued commands against the operator stack and emits results.
// Depends on itp_pkg and itp_ram.
module itp_back import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  back_state_e   state_q, state_d;
  cmd_t          cmd_q;
  logic [CW-1:0] count_q, count_d;
  logic          top_ok_q, top_ok_d;
  logic          open_seen_q, open_seen_d;
  logic          pend_valid_q, pend_valid_d;
  out_item_t     pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          push, pop, gen, release_last, out_load;
  out_item_t     gen_res;
  logic [2:0]    top_code;
  logic          empty, full, out_free, can_gen, take, pop_cand;
  back_state_e   nxt;

  itp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (AW'(count_q)),
    .wdata_i (cmd_q.code),
    .raddr_i (AW'(count_q - 1'b1)),
    .rdata_o (top_code)
  );

  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign can_gen  = !pend_valid_q || out_free;
  assign nxt      = cmd_q.end_of_expression ? ST_FLUSH : ST_IDLE;
  assign pop_cand = (cmd_q.kind == KIND_OPER) && !empty && (top_code != CODE_OPEN) &&
                    (code_prec(top_code) >= code_prec(cmd_q.code));

  always_comb begin
    state_d      = state_q;
    open_seen_d  = open_seen_q;
    push         = 1'b0;
    pop          = 1'b0;
    gen          = 1'b0;
    gen_res      = '0;
    release_last = 1'b0;
    take         = 1'b0;
    cmd_pop_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // the held result of the previous item goes out marked as its last
        release_last = pend_valid_q && out_free;
        take         = !pend_valid_q || out_free;
        if (take && cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          open_seen_d = 1'b0;
          state_d     = ST_MAIN;
        end
      end

      ST_MAIN: begin
        unique case (cmd_q.kind)
          KIND_LETTER: begin
            if (can_gen) begin
              gen                = 1'b1;
              gen_res.out_symbol = cmd_q.symbol;
              gen_res.has_symbol = 1'b1;
              state_d            = nxt;
            end
          end
          KIND_OPEN, KIND_OPER: begin
            if ((cmd_q.kind == KIND_OPER) && !empty && !top_ok_q) begin
              // hold until the stack top has been read back
            end else if (pop_cand) begin
              if (can_gen) begin
                gen                = 1'b1;
                gen_res.out_symbol = code_char(top_code);
                gen_res.has_symbol = 1'b1;
                pop                = 1'b1;
              end
            end else if (full) begin
              if (can_gen) begin
                gen            = 1'b1;
                gen_res.status = STATUS_OVERFLOW;
                state_d        = nxt;
              end
            end else begin
              push    = 1'b1;
              state_d = nxt;
            end
          end
          KIND_CLOSE: begin
            if (empty) begin
              if (can_gen) begin
                gen            = 1'b1;
                gen_res.status = STATUS_UNMATCHED_C;
                state_d        = nxt;
              end
            end else if (!top_ok_q) begin
              // hold until the stack top has been read back
            end else if (top_code == CODE_OPEN) begin
              pop     = 1'b1;
              state_d = nxt;
            end else if (can_gen) begin
              gen                = 1'b1;
              gen_res.out_symbol = code_char(top_code);
              gen_res.has_symbol = 1'b1;
              pop                = 1'b1;
            end
          end
          default: state_d = nxt;
        endcase
      end

      ST_FLUSH: begin
        if (empty) begin
          if (can_gen) begin
            gen                     = 1'b1;
            gen_res.status          = open_seen_q ? STATUS_UNMATCHED_O : STATUS_OK;
            gen_res.expression_done = 1'b1;
            state_d                 = ST_IDLE;
          end
        end else if (!top_ok_q) begin
          // hold until the stack top has been read back
        end else if (top_code == CODE_OPEN) begin
          pop         = 1'b1;
          open_seen_d = 1'b1;
        end else if (can_gen) begin
          gen                = 1'b1;
          gen_res.out_symbol = code_char(top_code);
          gen_res.has_symbol = 1'b1;
          pop                = 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // One result is held back until the next one shows whether it is the last.
  always_comb begin
    out_load     = release_last || (gen && pend_valid_q);
    out_d        = pend_q;
    out_d.run_last = release_last;
    pend_d       = gen ? gen_res : pend_q;
    pend_valid_d = gen ? 1'b1 : (release_last ? 1'b0 : pend_valid_q);
    out_valid_d  = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    top_ok_d     = !(push || pop);
    count_d      = count_q;
    if (push) begin
      count_d = count_q + 1'b1;
    end else if (pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      top_ok_q     <= 1'b0;
      open_seen_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      top_ok_q     <= top_ok_d;
      open_seen_q  <= open_seen_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/itp_checker.sv -----
// Port-level checks of the infix-to-postfix converter, bound to the top level.
// Depends on itp_pkg and infix_to_postfix_converter.
module itp_checker import itp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a waiting input transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.expression_done |->
      out_item_o.run_last && !out_item_o.has_symbol)
    else $error("end of expression result not last or carries a symbol");

  a_symbol_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.has_symbol |->
      (out_item_o.status == STATUS_OK) && !out_item_o.expression_done)
    else $error("symbol result with status or done flag");

  a_status_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_symbol |-> (out_item_o.out_symbol == 8'h00))
    else $error("status result carries a character");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
